### design/grid_local_minimum_risk_sum_macros.svh
// Assertion macros shared by the local minimum detector.
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_MACROS_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GLMRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("glmrs same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define GLMRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("glmrs next-cycle check failed");

`endif

### design/glmrs_pkg.sv
// Package: field widths, register indices and row buffer entry type.
`default_nettype none

package glmrs_pkg;

    localparam int PIX_W       = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int RISK_W      = 19;
    localparam int COUNT_W     = 15;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0]  REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET        = 8'd100;

    // One row buffer entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } t_row_entry;

endpackage

`default_nettype wire

### design/glmrs_row_buf.sv
// Row buffer memory: one write port, two registered read ports with write bypass.
`default_nettype none

module glmrs_row_buf #(
    parameter int AW = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire glmrs_pkg::t_row_entry i_wr_data,
    input  wire logic [AW-1:0]         i_rd_addr_a,
    input  wire logic [AW-1:0]         i_rd_addr_b,
    output glmrs_pkg::t_row_entry      o_rd_data_a,
    output glmrs_pkg::t_row_entry      o_rd_data_b
);

    localparam int DEPTH = 1 << AW;

    glmrs_pkg::t_row_entry r_mem [DEPTH];
    glmrs_pkg::t_row_entry r_rd_a;
    glmrs_pkg::t_row_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Forward the word being written when a read hits the same entry.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
            r_rd_a <= i_wr_data;
        end else begin
            r_rd_a <= r_mem[i_rd_addr_a];
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
            r_rd_b <= i_wr_data;
        end else begin
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

### design/grid_local_minimum_risk_sum.sv
// Top level: four-neighbour local minimum detector with per-frame risk sum.
//
//  channel   direction  handshake                        payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  pixel_height
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  risk_total, minima_count
//  cfg       in         i_cfg_valid/o_cfg_ready          register index, data
//
// One pixel word is taken in every cycle but at the stall below; the rate is set by
// the single pass from the row buffer read registers through the judges to the
// accumulators. One result word is registered when the frame's last pixel is taken.
// Reset (synchronous, active low) restores 100 x 100 and clears the position
// and sums; the row buffer needs no clearing pass, only this frame's rows are read.
// The input stalls only when the frame's last pixel arrives while a previous
// result still waits downstream; all other pixels are taken regardless.
`default_nettype none

module grid_local_minimum_risk_sum #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: [3:0] pixel_height, [7:4] zero
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [glmrs_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tdata: [18:0] risk_total, [33:19] minima_count, [39:34] zero
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic [glmrs_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [glmrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [glmrs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    `include "grid_local_minimum_risk_sum_macros.svh"

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WD_W   = $clog2(MAX_WIDTH + 1) + 1;
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1) + 1;
    localparam int WL_W   = (WD_W > glmrs_pkg::CFG_DATA_W) ? WD_W : glmrs_pkg::CFG_DATA_W;
    localparam int HL_W   = (HD_W > glmrs_pkg::CFG_DATA_W) ? HD_W : glmrs_pkg::CFG_DATA_W;
    localparam int PIX_W  = glmrs_pkg::PIX_W;
    localparam int RISK_W = glmrs_pkg::RISK_W;
    localparam int CNT_W  = glmrs_pkg::COUNT_W;
    localparam int PAD_W  = glmrs_pkg::OUT_TDATA_W - RISK_W - CNT_W;

    // True when every neighbour that is present lies strictly higher.
    function automatic logic is_min(
        input logic [PIX_W-1:0] ctr,
        input logic             has_u, input logic [PIX_W-1:0] val_u,
        input logic             has_l, input logic [PIX_W-1:0] val_l,
        input logic             has_r, input logic [PIX_W-1:0] val_r,
        input logic             has_d, input logic [PIX_W-1:0] val_d
    );
        return !((has_u && (val_u <= ctr)) || (has_l && (val_l <= ctr)) ||
                 (has_r && (val_r <= ctr)) || (has_d && (val_d <= ctr)));
    endfunction

    // ---------------------------------------------------------------- config
    logic [glmrs_pkg::CFG_DATA_W-1:0] r_frame_width;
    logic [glmrs_pkg::CFG_DATA_W-1:0] r_frame_height;
    logic                             cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= glmrs_pkg::DIM_RESET;
            r_frame_height <= glmrs_pkg::DIM_RESET;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                glmrs_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                glmrs_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the dimensions: zero counts as one, oversize saturates.
    logic [WL_W-1:0] width_ext;
    logic [HL_W-1:0] height_ext;
    logic [WD_W-1:0] dim_w;
    logic [HD_W-1:0] dim_h;

    always_comb begin
        width_ext  = WL_W'(r_frame_width);
        height_ext = HL_W'(r_frame_height);
        if (width_ext == '0) begin
            dim_w = WD_W'(1);
        end else if (width_ext > WL_W'(MAX_WIDTH)) begin
            dim_w = WD_W'(MAX_WIDTH);
        end else begin
            dim_w = WD_W'(width_ext);
        end
        if (height_ext == '0) begin
            dim_h = HD_W'(1);
        end else if (height_ext > HL_W'(MAX_HEIGHT)) begin
            dim_h = HD_W'(MAX_HEIGHT);
        end else begin
            dim_h = HD_W'(height_ext);
        end
    end

    // ---------------------------------------------------------------- position
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              last_col, last_row, frame_end;
    logic              in_acc;

    assign last_col  = (WD_W'(r_col) + WD_W'(1)) == dim_w;
    assign last_row  = (HD_W'(r_row) + HD_W'(1)) == dim_h;
    assign frame_end = last_col && last_row;

    // Hold the frame's last pixel back only while the previous result waits.
    logic r_out_valid;
    assign o_s_axis_tready = !(frame_end && r_out_valid && !i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (!i_rst_n || cfg_acc) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_row <= n_row;
    end

    // ---------------------------------------------------------------- row buffer
    // Port a reads the entry under the next pixel, port b the one to its right.
    glmrs_pkg::t_row_entry here_q, right_q, wr_word;
    logic [PIX_W-1:0]      px;

    assign px             = i_s_axis_tdata[PIX_W-1:0];
    assign wr_word.upper  = here_q.middle;
    assign wr_word.middle = px;

    glmrs_row_buf #(
        .AW (COL_W)
    ) u_row_buf (
        .i_clk       (i_clk),
        .i_wr_en     (in_acc && !cfg_acc),
        .i_wr_addr   (r_col),
        .i_wr_data   (wr_word),
        .i_rd_addr_a (n_col),
        .i_rd_addr_b (n_col + COL_W'(1)),
        .o_rd_data_a (here_q),
        .o_rd_data_b (right_q)
    );

    // Recent pixels of the current row and the row above, to the left.
    logic [PIX_W-1:0] r_left_up;
    logic [PIX_W-1:0] r_px1;
    logic [PIX_W-1:0] r_px2;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left_up <= here_q.middle;
            r_px1     <= px;
            r_px2     <= r_px1;
        end
    end

    // ---------------------------------------------------------------- judges
    logic r_ge1, r_ge2, c_ge1, c_ge2;
    logic hit_above, hit_left, hit_self;

    assign r_ge1 = (r_row != '0);
    assign r_ge2 = (HD_W'(r_row) >= HD_W'(2));
    assign c_ge1 = (r_col != '0);
    assign c_ge2 = (WD_W'(r_col) >= WD_W'(2));

    // The pixel directly above the arriving one.
    assign hit_above = r_ge1 && is_min(here_q.middle,
                                       r_ge2, here_q.upper,
                                       c_ge1, r_left_up,
                                       !last_col, right_q.middle,
                                       1'b1, px);
    // On the last row: the left neighbour of the arriving pixel.
    assign hit_left = last_row && c_ge1 && is_min(r_px1,
                                                  r_ge1, r_left_up,
                                                  c_ge2, r_px2,
                                                  1'b1, px,
                                                  1'b0, '0);
    // The frame's last pixel decides itself.
    assign hit_self = frame_end && is_min(px,
                                          r_ge1, here_q.middle,
                                          c_ge1, r_px1,
                                          1'b0, '0,
                                          1'b0, '0);

    // ---------------------------------------------------------------- sums
    logic [RISK_W-1:0] r_risk, n_risk;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [6:0]        risk_add;
    logic [1:0]        count_add;
    logic [RISK_W:0]   risk_sum;
    logic [CNT_W:0]    count_sum;

    always_comb begin
        risk_add  = (hit_above ? 7'(here_q.middle) + 7'd1 : 7'd0)
                  + (hit_left  ? 7'(r_px1) + 7'd1         : 7'd0)
                  + (hit_self  ? 7'(px) + 7'd1            : 7'd0);
        count_add = 2'(hit_above) + 2'(hit_left) + 2'(hit_self);
        risk_sum  = (RISK_W + 1)'(r_risk) + (RISK_W + 1)'(risk_add);
        count_sum = (CNT_W + 1)'(r_count) + (CNT_W + 1)'(count_add);
        // Saturate at the all-ones value of each field.
        n_risk    = risk_sum[RISK_W] ? '1 : risk_sum[RISK_W-1:0];
        n_count   = count_sum[CNT_W] ? '1 : count_sum[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_acc) begin
            r_risk  <= '0;
            r_count <= '0;
        end else if (in_acc) begin
            if (frame_end) begin
                r_risk  <= '0;
                r_count <= '0;
            end else begin
                r_risk  <= n_risk;
                r_count <= n_count;
            end
        end
    end

    // ---------------------------------------------------------------- output
    logic [RISK_W-1:0] r_out_risk;
    logic [CNT_W-1:0]  r_out_count;
    logic              load_out;

    assign load_out = in_acc && frame_end && !cfg_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_risk  <= n_risk;
            r_out_count <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_out_count, r_out_risk};

    // ---------------------------------------------------------------- checks
    `GLMRS_ASSERT_IMP(a_col_in_frame, i_clk, i_rst_n, 1'b1, (WD_W'(r_col) < dim_w))
    `GLMRS_ASSERT_IMP(a_stall_only_at_end, i_clk, i_rst_n, !o_s_axis_tready,
                      (r_out_valid && frame_end))
    `GLMRS_ASSERT_NXT(a_cfg_restarts, i_clk, i_rst_n, cfg_acc,
                      ((r_col == '0) && (r_row == '0) && (r_risk == '0) && (r_count == '0)))
    `GLMRS_ASSERT_IMP(a_result_from_end, i_clk, i_rst_n, $rose(r_out_valid),
                      $past(in_acc && frame_end))

endmodule

`default_nettype wire
